FILE: sv/lc3_pkg.sv
package lc3_pkg;

  typedef logic [15:0] word_t;

  // input item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_EXEC  = 2'd2;
  localparam logic [1:0] MODE_REGRD = 2'd3;

  // register select codes beyond the general registers
  localparam logic [3:0] SEL_PC = 4'd8;
  localparam logic [3:0] SEL_CC = 4'd9;

  // opcodes
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // condition flags
  localparam logic [2:0] FLAG_P = 3'b001;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_N = 3'b100;

  localparam word_t PC_RESET = 16'h3000;
  localparam logic [2:0] LINK_REG = 3'd7;

  typedef struct packed {
    logic [1:0] mode;
    word_t      address;
    word_t      data;
    logic [3:0] reg_select;
  } item_t;

  typedef struct packed {
    word_t      read_value;
    word_t      pc_now;
    logic [2:0] cond_flags;
    logic       fault;
    logic       reg_written;
    logic [2:0] dest_index;
    logic       mem_written;
  } result_t;

  typedef struct packed {
    logic  en;
    logic  we;
    word_t addr;
    word_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic       rd_en;
    logic [2:0] ra;
    logic [2:0] rb;
    logic       we;
    logic [2:0] wa;
    word_t      wd;
  } rf_req_t;

  function automatic word_t sext5(input word_t v);
    return {{11{v[4]}}, v[4:0]};
  endfunction

  function automatic word_t sext6(input word_t v);
    return {{10{v[5]}}, v[5:0]};
  endfunction

  function automatic word_t sext9(input word_t v);
    return {{7{v[8]}}, v[8:0]};
  endfunction

  function automatic word_t sext11(input word_t v);
    return {{5{v[10]}}, v[10:0]};
  endfunction

  function automatic logic [2:0] flags_of(input word_t v);
    if (v == 16'd0) begin
      return FLAG_Z;
    end else if (v[15]) begin
      return FLAG_N;
    end else begin
      return FLAG_P;
    end
  endfunction

  function automatic logic is_fault_op(input logic [3:0] op);
    return (op == OP_RTI) || (op == OP_RES) || (op == OP_TRAP);
  endfunction

  function automatic logic is_store_op(input logic [3:0] op);
    return (op == OP_ST) || (op == OP_STI) || (op == OP_STR);
  endfunction

endpackage

FILE: sv/lc3_if.sv
interface lc3_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [15:0] data;
  logic [3:0]  reg_select;

  modport source(output valid, output mode, output address, output data,
                 output reg_select, input ready);
  modport sink(input valid, input mode, input address, input data,
               input reg_select, output ready);
endinterface

interface lc3_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [15:0] pc_now;
  logic [2:0]  cond_flags;
  logic        fault;
  logic        reg_written;
  logic [2:0]  dest_index;
  logic        mem_written;

  modport source(output valid, output read_value, output pc_now, output cond_flags,
                 output fault, output reg_written, output dest_index,
                 output mem_written, input ready);
  modport sink(input valid, input read_value, input pc_now, input cond_flags,
               input fault, input reg_written, input dest_index,
               input mem_written, output ready);
endinterface

FILE: sv/lc3_instruction_execute_core_unit.sv
// channel | dir | payload                                         | handshake
// --------+-----+-------------------------------------------------+------------------
// req     | in  | mode, address, data, reg_select                 | valid/ready
// rsp     | out | read_value, pc_now, cond_flags, fault,          | valid/ready
//         |     | reg_written, dest_index, mem_written            |
// cfg     | in  | cfg_data (start_pc)                             | cfg_we, no ready
//
// each memory access is one pass through the single-port synchronous word memory
// a one-deep request buffer takes the next item while the current one executes,
//   and a result register lets work go on while a result waits on rsp
// reset (rst, synchronous) sets pc to 0x3000, the flags to zero-flag-set and the
//   registers to zero; main memory is not cleared
// a stall on rsp holds the sequencer at the step that would deliver the result
module lc3_instruction_execute_core_unit #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  lc3_req_if.sink     req,
  lc3_rsp_if.source   rsp
);
  import lc3_pkg::*;

  // start value register; reset restores the default, which is also pc's reset
  word_t start_pc;

  // request buffer
  logic  buf_valid;
  item_t buf_item;
  item_t req_item;
  logic  take;

  // result register
  logic    out_valid;
  result_t out_res;
  logic    emit_ok;
  logic    res_valid;
  result_t res;

  // memory and register file ports
  mem_req_t mem_req;
  word_t    mem_rdata;
  rf_req_t  rf_req;
  word_t    rf_rdata_a;
  word_t    rf_rdata_b;
  word_t    pc_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= PC_RESET;
    end else if (cfg_we) begin
      start_pc <= cfg_data;
    end
  end

  assign req_item = '{mode: req.mode, address: req.address, data: req.data,
                      reg_select: req.reg_select};

  // buffer frees up in the same cycle the sequencer takes its item
  assign req.ready = !buf_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      buf_item <= req_item;
    end
  end

  // result slot is free when empty or being drained this cycle
  assign emit_ok = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_res.read_value;
  assign rsp.pc_now      = out_res.pc_now;
  assign rsp.cond_flags  = out_res.cond_flags;
  assign rsp.fault       = out_res.fault;
  assign rsp.reg_written = out_res.reg_written;
  assign rsp.dest_index  = out_res.dest_index;
  assign rsp.mem_written = out_res.mem_written;

  // fetch / decode / execute sequencer, owns pc and flags
  lc3_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (buf_valid),
    .item       (buf_item),
    .take       (take),
    .emit_ok    (emit_ok),
    .res_valid  (res_valid),
    .res        (res),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .rf_req     (rf_req),
    .rf_rdata_a (rf_rdata_a),
    .rf_rdata_b (rf_rdata_b),
    .pc_cur     (pc_cur)
  );

  // word memory, one access per cycle
  lc3_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // general registers, two reads and one write per cycle
  lc3_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .req     (rf_req),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

`ifndef ASSERT_OFF
  a_emit_into_free_slot : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || rsp.ready))
    else $error("result produced while result register is occupied");

  a_take_from_full_buffer : assert property (@(posedge clk) disable iff (rst)
    take |-> buf_valid)
    else $error("sequencer took an item from an empty request buffer");

  a_pc_restarts : assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (pc_cur == start_pc))
    else $error("pc does not match start value after reset");
`endif

endmodule

FILE: sv/lc3_mem.sv
module lc3_mem #(
  parameter int ADDR_BITS = 16
) (
  input  logic              clk,
  input  lc3_pkg::mem_req_t req,
  output lc3_pkg::word_t    rdata
);
  import lc3_pkg::*;

  word_t mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.en && !req.we) begin
      rdata <= mem[req.addr[ADDR_BITS-1:0]];
    end
  end

endmodule

FILE: sv/lc3_regfile.sv
module lc3_regfile (
  input  logic             clk,
  input  logic             rst,
  input  lc3_pkg::rf_req_t req,
  output lc3_pkg::word_t   rdata_a,
  output lc3_pkg::word_t   rdata_b
);
  import lc3_pkg::*;

  word_t      regs [8];
  logic [7:0] valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.wa] <= req.wd;
    end
  end

  // never-written registers read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_a <= valid[req.ra] ? regs[req.ra] : '0;
      rdata_b <= valid[req.rb] ? regs[req.rb] : '0;
    end
  end

endmodule

FILE: sv/lc3_seq.sv
module lc3_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  lc3_pkg::item_t    item,
  output logic              take,
  input  logic              emit_ok,
  output logic              res_valid,
  output lc3_pkg::result_t  res,
  output lc3_pkg::mem_req_t mem_req,
  input  lc3_pkg::word_t    mem_rdata,
  output lc3_pkg::rf_req_t  rf_req,
  input  lc3_pkg::word_t    rf_rdata_a,
  input  lc3_pkg::word_t    rf_rdata_b,
  output lc3_pkg::word_t    pc_cur
);
  import lc3_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RESP   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_INDIR  = 3'd4;
  localparam logic [2:0] ST_LOADW  = 3'd5;

  logic [2:0] state, state_next;
  item_t      cur;
  word_t      ins;
  word_t      pc, pc_next;
  logic [2:0] cc, cc_next;

  logic [3:0] op, dec_op;
  logic [2:0] r0;
  word_t      npc, ea_pc, ea_base, alu_b, alu_val;

  assign op      = ins[15:12];
  assign dec_op  = mem_rdata[15:12];
  assign r0      = ins[11:9];
  assign npc     = pc + 16'd1;
  assign ea_pc   = npc + sext9(ins);
  assign ea_base = rf_rdata_a + sext6(ins);
  assign alu_b   = ins[5] ? sext5(ins) : rf_rdata_b;
  assign pc_cur  = pc;

  always_comb begin
    case (op)
      OP_ADD:  alu_val = rf_rdata_a + alu_b;
      OP_AND:  alu_val = rf_rdata_a & alu_b;
      OP_NOT:  alu_val = ~rf_rdata_a;
      default: alu_val = ea_pc;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    res.pc_now = pc;
    res.cond_flags = cc;
    mem_req    = '0;
    rf_req     = '0;
    state_next = state;
    pc_next    = pc;
    cc_next    = cc;

    case (state)
      ST_IDLE: begin
        if (item_valid && (item.mode != MODE_WRITE || emit_ok)) begin
          take = 1'b1;
          case (item.mode)
            MODE_WRITE: begin
              mem_req.en     = 1'b1;
              mem_req.we     = 1'b1;
              mem_req.addr   = item.address;
              mem_req.wdata  = item.data;
              res_valid      = 1'b1;
              res.read_value = item.data;
            end
            MODE_READ: begin
              mem_req.en   = 1'b1;
              mem_req.addr = item.address;
              state_next   = ST_RESP;
            end
            MODE_EXEC: begin
              mem_req.en   = 1'b1;
              mem_req.addr = pc;
              state_next   = ST_DECODE;
            end
            default: begin
              rf_req.rd_en = 1'b1;
              rf_req.ra    = item.reg_select[2:0];
              state_next   = ST_RESP;
            end
          endcase
        end
      end

      ST_RESP: begin
        if (emit_ok) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
          if (cur.mode == MODE_READ) begin
            res.read_value = mem_rdata;
          end else if (!cur.reg_select[3]) begin
            res.read_value = rf_rdata_a;
          end else if (cur.reg_select == SEL_PC) begin
            res.read_value = pc;
          end else if (cur.reg_select == SEL_CC) begin
            res.read_value = {13'd0, cc};
          end
        end
      end

      ST_DECODE: begin
        if (is_fault_op(dec_op)) begin
          if (emit_ok) begin
            res_valid  = 1'b1;
            res.fault  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          rf_req.rd_en = 1'b1;
          rf_req.ra    = mem_rdata[8:6];
          rf_req.rb    = is_store_op(dec_op) ? mem_rdata[11:9] : mem_rdata[2:0];
          state_next   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op)
          OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
            if (emit_ok) begin
              rf_req.we = 1'b1;
              rf_req.wa = r0;
              rf_req.wd = alu_val;
              cc_next   = flags_of(alu_val);
              pc_next   = npc;
              res_valid = 1'b1;
              res.read_value  = alu_val;
              res.reg_written = 1'b1;
              res.dest_index  = r0;
              res.pc_now      = npc;
              res.cond_flags  = flags_of(alu_val);
              state_next      = ST_IDLE;
            end
          end
          OP_BR, OP_JMP: begin
            if (emit_ok) begin
              if (op == OP_JMP) begin
                pc_next = rf_rdata_a;
              end else if ((ins[11:9] & cc) != 3'd0) begin
                pc_next = ea_pc;
              end else begin
                pc_next = npc;
              end
              res_valid  = 1'b1;
              res.pc_now = pc_next;
              state_next = ST_IDLE;
            end
          end
          OP_JSR: begin
            if (emit_ok) begin
              // target uses the base value read before the link write
              pc_next   = ins[11] ? npc + sext11(ins) : rf_rdata_a;
              rf_req.we = 1'b1;
              rf_req.wa = LINK_REG;
              rf_req.wd = npc;
              res_valid = 1'b1;
              res.read_value  = npc;
              res.reg_written = 1'b1;
              res.dest_index  = LINK_REG;
              res.pc_now      = pc_next;
              state_next      = ST_IDLE;
            end
          end
          OP_LD, OP_LDI, OP_STI: begin
            mem_req.en   = 1'b1;
            mem_req.addr = ea_pc;
            state_next   = (op == OP_LD) ? ST_LOADW : ST_INDIR;
          end
          OP_LDR: begin
            mem_req.en   = 1'b1;
            mem_req.addr = ea_base;
            state_next   = ST_LOADW;
          end
          OP_ST, OP_STR: begin
            if (emit_ok) begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.addr  = (op == OP_ST) ? ea_pc : ea_base;
              mem_req.wdata = rf_rdata_b;
              pc_next       = npc;
              res_valid     = 1'b1;
              res.read_value  = rf_rdata_b;
              res.mem_written = 1'b1;
              res.pc_now      = npc;
              state_next      = ST_IDLE;
            end
          end
          default: begin
            if (emit_ok) begin
              res_valid  = 1'b1;
              res.fault  = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end

      ST_INDIR: begin
        if (op == OP_LDI) begin
          mem_req.en   = 1'b1;
          mem_req.addr = mem_rdata;
          state_next   = ST_LOADW;
        end else if (emit_ok) begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = mem_rdata;
          mem_req.wdata = rf_rdata_b;
          pc_next       = npc;
          res_valid     = 1'b1;
          res.read_value  = rf_rdata_b;
          res.mem_written = 1'b1;
          res.pc_now      = npc;
          state_next      = ST_IDLE;
        end
      end

      ST_LOADW: begin
        if (emit_ok) begin
          rf_req.we = 1'b1;
          rf_req.wa = r0;
          rf_req.wd = mem_rdata;
          cc_next   = flags_of(mem_rdata);
          pc_next   = npc;
          res_valid = 1'b1;
          res.read_value  = mem_rdata;
          res.reg_written = 1'b1;
          res.dest_index  = r0;
          res.pc_now      = npc;
          res.cond_flags  = flags_of(mem_rdata);
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= PC_RESET;
      cc    <= FLAG_Z;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      cc    <= cc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= item;
    end
    if (state == ST_DECODE) begin
      ins <= mem_rdata;
    end
  end

endmodule

FILE: bench/lc3_instruction_execute_core_unit_tb.sv
`timescale 1ns / 1ps

// lc3 core bench: host memory access, register reads, every opcode and the
// corner cases of execution, then a long random mix of short programs, host
// writes and reads, all checked against an in-bench model of the core state
module lc3_instruction_execute_core_unit_tb;
  import lc3_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // general register numbers used when building instructions
  localparam logic [2:0] R0 = 3'd0;
  localparam logic [2:0] R1 = 3'd1;
  localparam logic [2:0] R2 = 3'd2;
  localparam logic [2:0] R3 = 3'd3;
  localparam logic [2:0] R4 = 3'd4;
  localparam logic [2:0] R5 = 3'd5;
  localparam logic [2:0] R6 = 3'd6;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_data;

  lc3_req_if req_ch ();
  lc3_rsp_if rsp_ch ();

  lc3_instruction_execute_core_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // architectural state as the core should hold it after every accepted transfer
  word_t arch_regs [8];
  word_t arch_pc;
  logic [2:0] arch_cc;
  word_t start_pc_shadow;   // last start value written; the core's pc never loads it
  word_t mem_image [word_t];
  word_t written_addrs [$];  // every address that holds a defined word

  result_t outcome_q [$];    // results still owed by the core, oldest first

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b1;              // random gaps on both sides
  int unsigned hold_cycles = 0;    // long receiver hold-off, consumed by the sink process
  int unsigned sink_gap = 0;

  // mostly back to back, sometimes a short pause, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // sign extend the low bits of an instruction field
  function automatic word_t sx(word_t v, int unsigned bits);
    logic signed [15:0] t;
    t = v << (16 - bits);
    return t >>> (16 - bits);
  endfunction

  function automatic logic [2:0] flags_for(word_t v);
    if (v == 16'd0) begin
      return FLAG_Z;
    end else if (v[15]) begin
      return FLAG_N;
    end else begin
      return FLAG_P;
    end
  endfunction

  function automatic void note_store(word_t addr, word_t v);
    if (!mem_image.exists(addr)) begin
      written_addrs.push_back(addr);
    end
    mem_image[addr] = v;
  endfunction

  // apply one accepted request to the architectural state and return the
  // result the core owes for it
  function automatic result_t compute_outcome(item_t it);
    result_t r;
    word_t ins;
    word_t npc;
    word_t ea;
    word_t val;
    logic [3:0] op;
    logic [2:0] dr;
    logic [2:0] sr1;
    bit wr;
    r = '0;
    wr = 1'b0;
    val = '0;
    case (it.mode)
      MODE_WRITE: begin
        note_store(it.address, it.data);
        r.read_value = it.data;
      end
      MODE_READ: begin
        r.read_value = mem_image[it.address];
      end
      MODE_REGRD: begin
        if (it.reg_select < SEL_PC) begin
          r.read_value = arch_regs[it.reg_select[2:0]];
        end else if (it.reg_select == SEL_PC) begin
          r.read_value = arch_pc;
        end else if (it.reg_select == SEL_CC) begin
          r.read_value = {13'd0, arch_cc};
        end
      end
      MODE_EXEC: begin
        ins = mem_image[arch_pc];
        op = ins[15:12];
        dr = ins[11:9];
        sr1 = ins[8:6];
        npc = arch_pc + 16'd1;
        if (op == OP_RTI || op == OP_RES || op == OP_TRAP) begin
          // faulting opcodes leave every piece of state alone
          r.fault = 1'b1;
        end else begin
          arch_pc = npc;
          case (op)
            OP_ADD, OP_AND: begin
              ea = ins[5] ? sx(ins, 5) : arch_regs[ins[2:0]];
              val = (op == OP_ADD) ? arch_regs[sr1] + ea : arch_regs[sr1] & ea;
              wr = 1'b1;
            end
            OP_NOT: begin
              val = ~arch_regs[sr1];
              wr = 1'b1;
            end
            OP_BR: begin
              if ((dr & arch_cc) != 3'd0) begin
                arch_pc = npc + sx(ins, 9);
              end
            end
            OP_JMP: begin
              arch_pc = arch_regs[sr1];
            end
            OP_JSR: begin
              // target taken before the link overwrites r7
              ea = ins[11] ? npc + sx(ins, 11) : arch_regs[sr1];
              arch_regs[LINK_REG] = npc;
              arch_pc = ea;
              r.read_value = npc;
              r.reg_written = 1'b1;
              r.dest_index = LINK_REG;
            end
            OP_LD: begin
              ea = npc + sx(ins, 9);
              val = mem_image[ea];
              wr = 1'b1;
            end
            OP_LDI: begin
              ea = npc + sx(ins, 9);
              val = mem_image[mem_image[ea]];
              wr = 1'b1;
            end
            OP_LDR: begin
              ea = arch_regs[sr1] + sx(ins, 6);
              val = mem_image[ea];
              wr = 1'b1;
            end
            OP_LEA: begin
              val = npc + sx(ins, 9);
              wr = 1'b1;
            end
            OP_ST: begin
              ea = npc + sx(ins, 9);
              r.read_value = arch_regs[dr];
              note_store(ea, arch_regs[dr]);
              r.mem_written = 1'b1;
            end
            OP_STI: begin
              ea = npc + sx(ins, 9);
              r.read_value = arch_regs[dr];
              note_store(mem_image[ea], arch_regs[dr]);
              r.mem_written = 1'b1;
            end
            OP_STR: begin
              ea = arch_regs[sr1] + sx(ins, 6);
              r.read_value = arch_regs[dr];
              note_store(ea, arch_regs[dr]);
              r.mem_written = 1'b1;
            end
            default: begin
            end
          endcase
          if (wr) begin
            arch_regs[dr] = val;
            arch_cc = flags_for(val);
            r.read_value = val;
            r.reg_written = 1'b1;
            r.dest_index = dr;
          end
        end
      end
      default: begin
      end
    endcase
    r.pc_now = arch_pc;
    r.cond_flags = arch_cc;
    return r;
  endfunction

  function automatic item_t make_item(logic [1:0] mode, word_t addr, word_t wdata,
                                      logic [3:0] sel);
    item_t it;
    it.mode = mode;
    it.address = addr;
    it.data = wdata;
    it.reg_select = sel;
    return it;
  endfunction

  // random instruction, faulting opcodes kept rare
  function automatic word_t random_ins();
    logic [3:0] op;
    logic [11:0] operand;
    op = 4'($urandom);
    if ((op == OP_RTI || op == OP_RES || op == OP_TRAP) && $urandom_range(0, 3) != 0) begin
      op = 4'($urandom_range(0, 7));
    end
    operand = 12'($urandom);
    return {op, operand};
  endfunction

  // one request transfer; valid stays up afterwards so the next item can
  // follow without a bubble
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= it.mode;
    req_ch.address <= it.address;
    req_ch.data <= it.data;
    req_ch.reg_select <= it.reg_select;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    outcome_q.push_back(compute_outcome(it));
    items_sent++;
  endtask

  task automatic poke(word_t addr, word_t v);
    send_item(make_item(MODE_WRITE, addr, v, 4'($urandom)));
  endtask

  task automatic peek(word_t addr);
    send_item(make_item(MODE_READ, addr, rand_word(), 4'($urandom)));
  endtask

  task automatic read_reg(logic [3:0] sel);
    send_item(make_item(MODE_REGRD, rand_word(), rand_word(), sel));
  endtask

  task automatic ensure_word(word_t addr);
    if (!mem_image.exists(addr)) begin
      poke(addr, rand_word());
    end
  endtask

  // the core must never read an undefined word: fill in whatever the
  // instruction at pc is about to load from
  task automatic ensure_operands(word_t ins);
    word_t npc;
    word_t ea;
    npc = arch_pc + 16'd1;
    case (ins[15:12])
      OP_LD, OP_STI: begin
        ensure_word(npc + sx(ins, 9));
      end
      OP_LDI: begin
        ea = npc + sx(ins, 9);
        ensure_word(ea);
        ensure_word(mem_image[ea]);
      end
      OP_LDR: begin
        ensure_word(arch_regs[ins[8:6]] + sx(ins, 6));
      end
      default: begin
      end
    endcase
  endtask

  task automatic exec_at_pc();
    ensure_operands(mem_image[arch_pc]);
    send_item(make_item(MODE_EXEC, rand_word(), rand_word(), 4'($urandom)));
  endtask

  task automatic run_instr(word_t ins);
    poke(arch_pc, ins);
    exec_at_pc();
  endtask

  // stop offering and wait for every owed result plus a settling margin
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_pc(word_t v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_pc_shadow = v;
  endtask

  task automatic random_step();
    int unsigned roll;
    int unsigned len;
    word_t base;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      // step the program: rerun what sits at pc or place a new instruction
      if (mem_image.exists(arch_pc) && $urandom_range(0, 1) == 1) begin
        exec_at_pc();
      end else begin
        run_instr(random_ins());
      end
    end else if (roll < 60) begin
      // lay down a short straight-line block that later steps walk through
      len = $urandom_range(3, 8);
      base = arch_pc;
      for (int unsigned j = 0; j < len; j++) begin
        poke(base + 16'(j), random_ins());
      end
    end else if (roll < 75) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        base = rand_word();
      end else if (roll < 8) begin
        base = arch_pc + 16'($urandom_range(0, 31));
      end else begin
        base = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      end
      poke(base, ($urandom_range(0, 7) == 0) ? 16'hFFFF : rand_word());
    end else if (roll < 85) begin
      if (written_addrs.size() != 0) begin
        peek(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      end
    end else begin
      read_reg(4'($urandom_range(0, 15)));
    end
  endtask

  // writing start_pc leaves pc and flags as they were
  task automatic test_start_pc_config();
    write_start_pc(16'h0000);
    write_start_pc(16'hFFFF);
    read_reg(SEL_PC);
    read_reg(SEL_CC);
    write_start_pc(rand_word());
    write_start_pc(PC_RESET);
    read_reg(SEL_PC);
    drain();
  endtask

  task automatic test_host_memory();
    poke(16'h0000, 16'hFFFF);
    poke(16'hFFFF, 16'h0000);
    poke(16'h5A5A, 16'hA5A5);
    peek(16'h0000);
    peek(16'hFFFF);
    peek(16'h5A5A);
    drain();
  endtask

  // every non-faulting opcode with operand extremes, run straight from 0x3000
  task automatic test_opcodes();
    word_t prog [$];
    prog = '{
      {OP_ADD, R1, R1, 1'b1, 5'h10},            // most negative imm5
      {OP_ADD, R2, R2, 1'b1, 5'h0F},            // most positive imm5
      {OP_ADD, R3, R1, 3'b000, R2},             // register form, all ones
      {OP_AND, R4, R3, 3'b000, R2},
      {OP_AND, R5, R3, 1'b1, 5'h00},            // zero result
      {OP_NOT, R6, R3, 6'h3F},
      {OP_LEA, R0, 9'h100},                     // farthest back
      {OP_ST, R3, 9'h0FF},                      // farthest ahead
      {OP_LD, R6, 9'h0FE},                      // same word the store wrote
      {OP_STR, R2, R1, 6'h20},
      {OP_LDR, R5, R1, 6'h20},
      {OP_LDR, R4, R2, 6'h1F},
      {OP_STI, R3, 9'h010},
      {OP_LDI, R0, 9'h00F},                     // through the sti pointer
      {OP_BR, FLAG_N | FLAG_Z | FLAG_P, 9'h0FF},
      {OP_JSR, 1'b1, 11'h3FF},
      {OP_JSR, 1'b1, 11'h400},
      {OP_JMP, 3'b000, R4, 6'h00}
    };
    foreach (prog[i]) begin
      run_instr(prog[i]);
    end
    drain();
  endtask

  task automatic test_corner_cases();
    word_t prog [$];
    prog = '{
      {OP_ADD, LINK_REG, R3, 1'b1, 5'h00},      // r7 = all ones
      {OP_JSR, 1'b0, 2'b00, LINK_REG, 6'h00},   // jsrr through r7 itself
      {OP_LEA, R0, 9'h000},                     // at 0xffff: pc wraps, lea gives zero
      {OP_RTI, 12'h000},
      {OP_RES, 12'hFFF},
      {OP_TRAP, 4'h0, 8'h25},
      {OP_BR, 3'b000, 9'h0FF},                  // no condition bits: never taken
      {OP_BR, FLAG_N, 9'h0FF},                  // flags say zero: not taken
      {OP_BR, FLAG_Z, 9'h100}                   // taken, wraps back below zero
    };
    foreach (prog[i]) begin
      run_instr(prog[i]);
    end
    drain();
  endtask

  // every select code, including the ones beyond the flags
  task automatic test_register_reads();
    for (int unsigned s = 0; s < 16; s++) begin
      read_reg(4'(s));
    end
    drain();
  endtask

  task automatic test_random_mix(int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) begin
      // every third block of a hundred runs with no idling at all
      idle_on = (((items_sent - first) / 100) % 3) != 2;
      random_step();
    end
    idle_on = 1'b1;
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the core backs up
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_cycles = 300;
    repeat (20) random_step();
    drain();
    idle_on = 1'b1;
  endtask

  // result side ready with random stalls and the occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles--;
    end else if (sink_gap != 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) begin
        sink_gap = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %h, actual %h", name, want, got);
    end
  endfunction

  // each result transfer against the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (outcome_q.size() == 0) begin
        fail_count++;
        $error("result with nothing owed: read_value %h pc_now %h",
               rsp_ch.read_value, rsp_ch.pc_now);
      end else begin
        want = outcome_q.pop_front();
        check_field("read_value", want.read_value, rsp_ch.read_value);
        check_field("pc_now", want.pc_now, rsp_ch.pc_now);
        check_field("cond_flags", 16'(want.cond_flags), 16'(rsp_ch.cond_flags));
        check_field("fault", 16'(want.fault), 16'(rsp_ch.fault));
        check_field("reg_written", 16'(want.reg_written), 16'(rsp_ch.reg_written));
        check_field("dest_index", 16'(want.dest_index), 16'(rsp_ch.dest_index));
        check_field("mem_written", 16'(want.mem_written), 16'(rsp_ch.mem_written));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_WRITE;
    req_ch.address <= '0;
    req_ch.data <= '0;
    req_ch.reg_select <= '0;

    // reset state of the model
    foreach (arch_regs[i]) begin
      arch_regs[i] = '0;
    end
    arch_pc = PC_RESET;
    arch_cc = FLAG_Z;
    start_pc_shadow = PC_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_start_pc_config();
    test_host_memory();
    test_opcodes();
    test_corner_cases();
    test_register_reads();
    test_random_mix(360);
    write_start_pc(rand_word());
    read_reg(SEL_PC);
    test_output_backpressure();
    test_register_reads();

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lc3_pkg.sv
sv/lc3_if.sv
sv/lc3_mem.sv
sv/lc3_regfile.sv
sv/lc3_seq.sv
sv/lc3_instruction_execute_core_unit.sv
bench/lc3_instruction_execute_core_unit_tb.sv
